// ===== rtl/core/sfc_pkg.sv =====
// Shared types, constants and a saturating add helper for the sphere frustum cull block.
// No dependencies; imported by sfc_cell and sphere_frustum_cull.
package sfc_pkg;

    localparam int NUM_PLANES_DEF = 6;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [1:0] MODE_PLANE  = 2'd0;
    localparam logic [1:0] MODE_MATRIX = 2'd1;
    localparam logic [1:0] MODE_BOX    = 2'd2;

    localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

    // A sphere on its way down the plane chain.
    typedef struct packed {
        logic               valid;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic        [63:0] rsq;
        logic               outside;
    } t_probe;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? SAT_MIN : SAT_MAX;
        end
        return s[63:0];
    endfunction

endpackage

// ===== rtl/core/sfc_cell.sv =====
// One plane cell of the culling chain: holds one plane and tests the passing sphere.
// Depends on sfc_pkg for the probe type and saturating add.
module sfc_cell #(
    parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  logic signed [31:0]  i_pt [3],
    input  logic signed [31:0]  i_nm [3],
    input  sfc_pkg::t_probe     i_probe,
    output sfc_pkg::t_probe     o_probe
);
    import sfc_pkg::*;

    logic signed [31:0] r_pt [3];
    logic signed [31:0] r_nm [3];

    t_probe             r_pa, r_pb, r_pc, n_pc;
    logic signed [63:0] r_prod [3];
    logic               r_neg, r_big;
    logic        [31:0] r_mag;

    logic signed [32:0] diff [3];
    logic signed [63:0] dot, d, negd;
    logic        [63:0] sq, dd;

    always_comb begin
        diff[0] = 33'(i_probe.cx) - 33'(r_pt[0]);
        diff[1] = 33'(i_probe.cy) - 33'(r_pt[1]);
        diff[2] = 33'(i_probe.cz) - 33'(r_pt[2]);
        dot  = sat_add64(sat_add64(r_prod[0], r_prod[1]), r_prod[2]);
        d    = dot >>> FRAC_BITS;
        negd = -d;
        sq   = r_mag * r_mag;
        dd   = (r_big || sq[63]) ? 64'(SAT_MAX) : sq;
        n_pc = r_pb;
        n_pc.outside = r_pb.outside | (r_neg && (dd > r_pb.rsq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_pt[k] <= '0;
                r_nm[k] <= '0;
            end
            r_pa <= '0;
            r_pb <= '0;
            r_pc <= '0;
        end else begin
            if (i_wr) begin
                r_pt <= i_pt;
                r_nm <= i_nm;
            end
            r_pa <= i_probe;
            r_pb <= r_pa;
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= 64'(65'(diff[k]) * 65'(r_nm[k]));
        end
        r_neg        <= d[63];
        r_big        <= d < -64'sh1_0000_0000 + 64'sd1;
        r_mag        <= negd[31:0];
    end

    assign o_probe = r_pc;

endmodule

// ===== rtl/core/sphere_frustum_cull.sv =====
// Top level of the sphere frustum cull block: item decode, matrix transform, chain control.
// Depends on sfc_pkg and sfc_cell.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  input   | in        | i_valid / o_ready  | i_mode, i_index, i_word0..5, i_last_mesh
//  output  | out       | o_valid / i_ready  | o_culled
//
// Plane and matrix words are absorbed in the cycle they are accepted.
// A box word holds the block from its accepting cycle while it passes the states in order:
// S_XF through the shared three-multiplier transform unit, S_RAD and S_RSUM for center and radius,
// S_CHAIN in the chain (the launch register, then three per plane cell), and S_DONE to finish.
// Reset is synchronous and active low; it clears planes, matrix and the outside flag.
// The result sits in an output register, so new words are taken while it waits; only a second
// result for a full output register holds the block until the first one is taken.
module sphere_frustum_cull #(
    parameter int NUM_PLANES = sfc_pkg::NUM_PLANES_DEF,
    parameter int FRAC_BITS  = sfc_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [2:0]         i_index,
    input  logic signed [31:0] i_word0,
    input  logic signed [31:0] i_word1,
    input  logic signed [31:0] i_word2,
    input  logic signed [31:0] i_word3,
    input  logic signed [31:0] i_word4,
    input  logic signed [31:0] i_word5,
    input  logic               i_last_mesh,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_culled
);
    import sfc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_XF    = 3'd1;
    localparam logic [2:0] S_RAD   = 3'd2;
    localparam logic [2:0] S_RSUM  = 3'd3;
    localparam logic [2:0] S_CHAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] XF_LAST = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_cnt;
    logic signed [31:0] r_mat [3][4];
    logic signed [31:0] r_w [6];
    logic               r_last;
    logic               r_seen;
    logic               r_o_valid, r_o_culled;

    // Transform unit: three products per step, accumulated the next cycle.
    logic               r_pv;
    logic [1:0]         r_prow;
    logic               r_pcor;
    logic signed [63:0] r_xp [3];
    logic signed [31:0] r_corner [2][3];

    logic signed [31:0] r_cen [3];
    logic signed [63:0] r_rsq_p [3];
    t_probe             r_launch, n_launch;

    logic               accept, xf_issue;
    logic [1:0]         xf_row;
    logic               xf_cor;
    logic signed [63:0] acc, shifted, tsum;
    logic signed [31:0] xf_out;
    logic signed [32:0] csum [3];
    logic signed [32:0] rv [3];
    logic signed [31:0] cen [3];
    logic signed [63:0] rsq;
    logic               emit;

    logic signed [31:0] wr_pt [3];
    logic signed [31:0] wr_nm [3];
    t_probe             chain [NUM_PLANES + 1];

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign xf_issue = (r_state == S_XF) && (r_cnt < XF_LAST);
    assign xf_cor   = (r_cnt >= 3'd3);
    assign xf_row   = xf_cor ? 2'(r_cnt - 3'd3) : r_cnt[1:0];
    assign emit     = (r_state == S_DONE) && r_last && (!r_o_valid || i_ready);

    assign wr_pt = '{i_word0, i_word1, i_word2};
    assign wr_nm = '{i_word3, i_word4, i_word5};

    always_comb begin
        acc     = sat_add64(sat_add64(r_xp[0], r_xp[1]), r_xp[2]);
        shifted = acc >>> FRAC_BITS;
        tsum    = shifted + 64'(r_mat[r_prow][3]);
        if (tsum > 64'sd2147483647) begin
            xf_out = 32'sh7FFF_FFFF;
        end else if (tsum < -64'sd2147483648) begin
            xf_out = 32'sh8000_0000;
        end else begin
            xf_out = tsum[31:0];
        end
        for (int k = 0; k < 3; k++) begin
            csum[k] = 33'(r_corner[1][k]) + 33'(r_corner[0][k]);
            cen[k]  = csum[k][32:1];
            rv[k]   = 33'(r_corner[1][k]) - 33'(cen[k]);
        end
        rsq = sat_add64(sat_add64(r_rsq_p[0], r_rsq_p[1]), r_rsq_p[2]);
        // The sphere enters the chain right after the radius sum.
        n_launch       = r_launch;
        n_launch.valid = (r_state == S_RSUM);
        if (r_state == S_RSUM) begin
            n_launch.cx      = r_cen[0];
            n_launch.cy      = r_cen[1];
            n_launch.cz      = r_cen[2];
            n_launch.rsq     = rsq;
            n_launch.outside = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && i_mode == MODE_BOX) n_state = S_XF;
            S_XF:    if (r_cnt == XF_LAST) n_state = S_RAD;
            S_RAD:   n_state = S_RSUM;
            S_RSUM:  n_state = S_CHAIN;
            S_CHAIN: if (chain[NUM_PLANES].valid) n_state = S_DONE;
            S_DONE:  if (!r_last || emit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pv      <= 1'b0;
            r_seen    <= 1'b0;
            r_o_valid <= 1'b0;
            r_launch  <= '0;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 4; k++) begin
                    r_mat[r][k] <= '0;
                end
            end
        end else begin
            r_state  <= n_state;
            r_pv     <= xf_issue;
            r_launch <= n_launch;
            if (r_state == S_XF) begin
                r_cnt <= r_cnt + 3'd1;
            end else begin
                r_cnt <= '0;
            end
            if (accept && i_mode == MODE_MATRIX && i_index < 3'd3) begin
                r_mat[i_index[1:0]][0] <= i_word0;
                r_mat[i_index[1:0]][1] <= i_word1;
                r_mat[i_index[1:0]][2] <= i_word2;
                r_mat[i_index[1:0]][3] <= i_word3;
            end
            // A new result may replace the one taken in the same cycle.
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == S_CHAIN && chain[NUM_PLANES].valid) begin
                r_seen <= r_seen | chain[NUM_PLANES].outside;
            end
            if (emit) begin
                r_seen <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w    <= '{i_word0, i_word1, i_word2, i_word3, i_word4, i_word5};
            r_last <= i_last_mesh;
        end
        if (xf_issue) begin
            r_prow <= xf_row;
            r_pcor <= xf_cor;
            for (int k = 0; k < 3; k++) begin
                r_xp[k] <= 64'(r_mat[xf_row][k]) * 64'(r_w[xf_cor ? k + 3 : k]);
            end
        end
        if (r_pv) begin
            r_corner[r_pcor][r_prow] <= xf_out;
        end
        if (r_state == S_RAD) begin
            for (int k = 0; k < 3; k++) begin
                r_cen[k]   <= cen[k];
                r_rsq_p[k] <= 64'(66'(rv[k]) * 66'(rv[k]));
            end
        end
        if (emit) begin
            r_o_culled <= r_seen;
        end
    end

    assign chain[0] = r_launch;

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
        sfc_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (accept && i_mode == MODE_PLANE && i_index == 3'(g)),
            .i_pt    (wr_pt),
            .i_nm    (wr_nm),
            .i_probe (chain[g]),
            .o_probe (chain[g + 1])
        );
    end

    assign o_valid  = r_o_valid;
    assign o_culled = r_o_culled;

    // A sphere leaves the chain only while the sequencer waits for it.
    a_chain_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[NUM_PLANES].valid |-> (r_state == S_CHAIN))
        else $error("sphere left the plane chain outside the wait state");

    // A result is only emitted for the final box of a mesh.
    a_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (r_last && r_state == S_DONE))
        else $error("result emitted for a non-final box");

    // The outside flag is clear once a result has been emitted.
    a_seen_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> !r_seen)
        else $error("outside flag survived a result");

endmodule
